// ===== src/pktb_pkg.sv =====
// ----------------------------------------------------------------------------
// pktb_pkg
// Shared types and constants for the per-key token bucket limiter.
// ----------------------------------------------------------------------------
package pktb_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 32;
    localparam int TIME_W        = 64;
    localparam int TOK_W         = 16;
    localparam int IVL_W         = 32;
    localparam int DIV_CNT_W     = 7;

    localparam logic [TOK_W-1:0] DEPTH_RESET    = 16'd20;
    localparam logic [IVL_W-1:0] INTERVAL_RESET = 32'd10000000;

    typedef enum logic [0:0] {
        REG_BUCKET_DEPTH = 1'b0,
        REG_REFILL_IVL   = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_DIVIDE,
        ST_UPDATE,
        ST_AGE,
        ST_OUTPUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch request
        logic scan_start;  // clear scan state, index 0
        logic scan_step;   // examine current index, advance
        logic div_start;
        logic div_step;
        logic commit;      // write back entry
        logic age_start;
        logic age_step;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic found;
        logic div_last;
        logic age_last;
    } status_t;

endpackage

// ===== src/pktb_ram.sv =====
// ----------------------------------------------------------------------------
// pktb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pktb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/pktb_ctrl.sv =====
// ----------------------------------------------------------------------------
// pktb_ctrl
// Sequencer: scan, optional divide, write back, age pass, output.
// ----------------------------------------------------------------------------
module pktb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_free,
    input  pktb_pkg::status_t sts,
    output logic              busy,
    output pktb_pkg::cmd_t    cmd
);

    pktb_pkg::state_t state_reg;
    pktb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pktb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != pktb_pkg::ST_IDLE);
        case (state_reg)
            pktb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = pktb_pkg::ST_SCAN;
                end
            end
            pktb_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = pktb_pkg::ST_SCAN_WAIT;
                end
            end
            pktb_pkg::ST_SCAN_WAIT:
            begin
                // last registered read is examined in this cycle
                cmd.scan_step = 1'b1;
                if (sts.found)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = pktb_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = pktb_pkg::ST_UPDATE;
                end
            end
            pktb_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = pktb_pkg::ST_UPDATE;
                end
            end
            pktb_pkg::ST_UPDATE:
            begin
                cmd.commit    = 1'b1;
                cmd.age_start = 1'b1;
                state_next    = pktb_pkg::ST_AGE;
            end
            pktb_pkg::ST_AGE:
            begin
                cmd.age_step = 1'b1;
                if (sts.age_last)
                begin
                    state_next = pktb_pkg::ST_OUTPUT;
                end
            end
            pktb_pkg::ST_OUTPUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pktb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pktb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/pktb_datapath.sv =====
// ----------------------------------------------------------------------------
// pktb_datapath
// Entry table, scan logic, serial divider, bucket arithmetic, LRU ranks.
// ----------------------------------------------------------------------------
module pktb_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pktb_pkg::cmd_t                  cmd,
    output pktb_pkg::status_t               sts,
    input  logic [pktb_pkg::KEY_W-1:0]      in_key,
    input  logic [pktb_pkg::TIME_W-1:0]     in_time,
    input  logic [pktb_pkg::TOK_W-1:0]      depth,
    input  logic [pktb_pkg::IVL_W-1:0]      interval,
    output logic                            res_limited,
    output logic [pktb_pkg::TOK_W-1:0]      res_tokens,
    output logic                            res_new
);

    localparam int IDX_W = pktb_pkg::IDX_W;
    localparam int CNT_W = pktb_pkg::CNT_W;
    localparam int TW    = pktb_pkg::TIME_W;
    localparam int KW    = pktb_pkg::KEY_W;
    localparam int TOKW  = pktb_pkg::TOK_W;
    localparam int RAM_W = KW + TOKW + TW;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(pktb_pkg::TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(pktb_pkg::TABLE_ENTRIES - 1);

    // request
    logic [KW-1:0]  key_reg;
    logic [TW-1:0]  now_reg;

    // per-entry flip-flops
    logic [pktb_pkg::TABLE_ENTRIES-1:0] valid_reg;

    // scan
    logic [CNT_W-1:0] scan_idx_reg;   // address presented to RAM
    logic [IDX_W-1:0] look_idx_reg;   // index whose data is on rdata
    logic             look_vld_reg;
    logic             found_reg;
    logic             free_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] hit_rank_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] lru_idx_reg;
    logic [IDX_W-1:0] lru_rank_reg;
    logic             lru_any_reg;
    logic [TOKW-1:0]  hit_tok_reg;
    logic [TW-1:0]    hit_time_reg;

    // divider
    logic [TW-1:0]    quo_reg;
    logic [TW:0]      rem_reg;
    logic [pktb_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    // commit
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] old_rank_reg;
    logic             old_full_reg;   // new key with no eviction: ages all
    logic [CNT_W-1:0] age_idx_reg;
    logic             age_pv_reg;     // rank of age_pidx_reg is on rank_rdata
    logic [IDX_W-1:0] age_pidx_reg;

    logic             we;
    logic [RAM_W-1:0] wdata;
    logic [RAM_W-1:0] rdata;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] slot_sel;

    logic             rank_we;
    logic [IDX_W-1:0] rank_wdata;
    logic [IDX_W-1:0] rank_raddr;
    logic [IDX_W-1:0] rank_rdata;

    assign raddr = scan_idx_reg[IDX_W-1:0];

    pktb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (pktb_pkg::TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (slot_sel),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // ranks: read beside the entry during the scan, read-modify-write in the age pass
    pktb_ram #(
        .WIDTH (IDX_W),
        .DEPTH (pktb_pkg::TABLE_ENTRIES)
    ) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (age_pidx_reg),
        .wdata (rank_wdata),
        .raddr (rank_raddr),
        .rdata (rank_rdata)
    );

    logic [KW-1:0]   rd_key;
    logic [TOKW-1:0] rd_tok;
    logic [TW-1:0]   rd_time;
    assign rd_key  = rdata[KW-1:0];
    assign rd_tok  = rdata[KW+TOKW-1:KW];
    assign rd_time = rdata[RAM_W-1:KW+TOKW];

    // ---------------- scan ----------------
    logic look_ok;
    assign look_ok = look_vld_reg && valid_reg[look_idx_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= in_key;
            now_reg <= in_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            look_vld_reg <= 1'b0;
            look_idx_reg <= '0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            lru_any_reg  <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
            look_vld_reg <= 1'b0;
            look_idx_reg <= '0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            lru_any_reg  <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (scan_idx_reg != CNT_W'(pktb_pkg::TABLE_ENTRIES))
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            look_vld_reg <= (scan_idx_reg != CNT_W'(pktb_pkg::TABLE_ENTRIES));
            look_idx_reg <= raddr;
            if (look_vld_reg)
            begin
                if (look_ok && rd_key == key_reg && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (!valid_reg[look_idx_reg] && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
                if (look_ok && (!lru_any_reg || rank_rdata > lru_rank_reg))
                begin
                    lru_any_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && look_vld_reg)
        begin
            if (look_ok && rd_key == key_reg && !found_reg)
            begin
                hit_idx_reg  <= look_idx_reg;
                hit_rank_reg <= rank_rdata;
                hit_tok_reg  <= rd_tok;
                hit_time_reg <= rd_time;
            end
            if (!valid_reg[look_idx_reg] && !free_reg)
            begin
                free_idx_reg <= look_idx_reg;
            end
            if (look_ok && (!lru_any_reg || rank_rdata > lru_rank_reg))
            begin
                lru_idx_reg  <= look_idx_reg;
                lru_rank_reg <= rank_rdata;
            end
        end
    end

    // found is combinational over the final look so the controller sees it
    // in the wait state
    logic found_now;
    assign found_now = found_reg ||
                       (look_vld_reg && look_ok && rd_key == key_reg);

    assign sts.scan_last = (scan_idx_reg == LAST_IDX);
    assign sts.found     = found_now;

    // ---------------- divider: restoring, one quotient bit a cycle -----------
    logic [TW-1:0]   elapsed;
    logic [TW:0]     rem_sh;
    logic [TW:0]     ivl_ext;
    logic [pktb_pkg::IVL_W-1:0] ivl_eff;

    assign ivl_eff = (interval == '0) ? pktb_pkg::IVL_W'(1) : interval;
    assign ivl_ext = (TW + 1)'(ivl_eff);
    // a hit on the final look is still on rdata when the divide starts
    assign elapsed = now_reg - (found_reg ? hit_time_reg : rd_time);
    assign rem_sh  = {rem_reg[TW-1:0], quo_reg[TW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= elapsed;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= ivl_ext)
            begin
                rem_reg <= rem_sh - ivl_ext;
                quo_reg <= {quo_reg[TW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[TW-2:0], 1'b0};
            end
        end
    end

    assign sts.div_last = (div_cnt_reg == pktb_pkg::DIV_CNT_W'(TW - 1));

    // ---------------- bucket update ----------------
    logic            earned_nz;
    logic            earned_big;
    logic [TOKW:0]   sum;
    logic [TOKW-1:0] refilled;
    logic [TOKW-1:0] tok_new;
    logic            lim_new;
    logic [TW-1:0]   time_new;
    logic [TOKW-1:0] start_tok;

    assign earned_nz  = (quo_reg != '0);
    assign earned_big = (quo_reg >= TW'(depth));
    assign sum        = (TOKW + 1)'(hit_tok_reg) + (TOKW + 1)'(quo_reg[TOKW-1:0]);
    always_comb
    begin
        if (!earned_nz)
        begin
            refilled = hit_tok_reg;
        end
        else if (earned_big || sum > (TOKW + 1)'(depth))
        begin
            refilled = depth;
        end
        else
        begin
            refilled = sum[TOKW-1:0];
        end
    end
    assign start_tok = (depth == '0) ? '0 : depth - 1'b1;
    assign lim_new   = found_reg && (refilled == '0);
    assign tok_new   = !found_reg ? start_tok :
                       (refilled == '0) ? refilled : refilled - 1'b1;
    assign time_new  = (!found_reg || earned_nz) ? now_reg : hit_time_reg;

    assign slot_sel = found_reg ? hit_idx_reg :
                      free_reg  ? free_idx_reg : lru_idx_reg;

    assign we    = cmd.commit;
    assign wdata = {time_new, tok_new, key_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_limited  <= lim_new;
            res_tokens   <= tok_new;
            res_new      <= !found_reg;
            old_rank_reg <= found_reg ? hit_rank_reg : lru_rank_reg;
            old_full_reg <= !found_reg && free_reg;
            slot_reg     <= slot_sel;
        end
    end

    // ---------------- age pass, one entry a cycle ----------------
    logic age_self;
    logic age_bump;

    assign rank_raddr = cmd.age_step ? age_idx_reg[IDX_W-1:0] : raddr;
    assign age_self   = (age_pidx_reg == slot_reg);
    assign age_bump   = valid_reg[age_pidx_reg] &&
                        (old_full_reg || rank_rdata < old_rank_reg);
    assign rank_we    = cmd.age_step && age_pv_reg && (age_self || age_bump);
    assign rank_wdata = age_self ? '0 : rank_rdata + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            age_idx_reg  <= '0;
            age_pv_reg   <= 1'b0;
            age_pidx_reg <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                valid_reg[slot_sel] <= 1'b1;
            end
            if (cmd.age_start)
            begin
                age_idx_reg <= '0;
                age_pv_reg  <= 1'b0;
            end
            else if (cmd.age_step)
            begin
                age_idx_reg  <= age_idx_reg + 1'b1;
                age_pv_reg   <= 1'b1;
                age_pidx_reg <= age_idx_reg[IDX_W-1:0];
            end
        end
    end

    assign sts.age_last = age_pv_reg && (age_pidx_reg == LAST_SLOT);

`ifndef SYNTHESIS
    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> div_cnt_reg < pktb_pkg::DIV_CNT_W'(TW))
        else $error("divider overran");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !cmd.scan_step && !cmd.div_step)
        else $error("commit during scan or divide");
    a_valid_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> valid_reg[slot_reg])
        else $error("committed slot not valid");
`endif

endmodule

// ===== src/per_key_token_bucket_limiter.sv =====
// ----------------------------------------------------------------------------
// per_key_token_bucket_limiter
// Per-key token bucket rate limiter with a 64-entry exact-LRU table.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake        Content
// s_axis    in   tvalid/tready    user_key, time_ns
// m_axis    out  tvalid/tready    limited, tokens_left, new_entry
// cfg       in   cfg_we           cfg_index, cfg_data
//
// One request at a time: a table scan (registered RAM read), a serial divide
// for a known key, one write-back and a rank update pass over every entry.
// Result is held in an output register; a new request is taken while it waits.
// Reset clears the valid bits at once; ranks sit in RAM and are written when
// an entry is made, so no clearing pass.
// ----------------------------------------------------------------------------
module per_key_token_bucket_limiter (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // user_key[31:0], time_ns[95:32]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // limited[0], tokens_left[16:1], new_entry[17]
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    pktb_pkg::cmd_t    cmd;
    pktb_pkg::status_t sts;
    logic              busy;
    logic              in_fire;
    logic              out_free;

    logic [pktb_pkg::TOK_W-1:0] depth_reg;
    logic [pktb_pkg::IVL_W-1:0] interval_reg;

    logic                       res_limited;
    logic [pktb_pkg::TOK_W-1:0] res_tokens;
    logic                       res_new;

    logic                       out_vld_reg;
    logic [17:0]                out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg    <= pktb_pkg::DEPTH_RESET;
            interval_reg <= pktb_pkg::INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            case (pktb_pkg::reg_index_t'(cfg_index))
                pktb_pkg::REG_BUCKET_DEPTH: depth_reg    <= cfg_data[15:0];
                pktb_pkg::REG_REFILL_IVL:   interval_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_vld_reg || m_axis_tready;

    pktb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .sts      (sts),
        .busy     (busy),
        .cmd      (cmd)
    );

    pktb_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_key      (s_axis_tdata[31:0]),
        .in_time     (s_axis_tdata[95:32]),
        .depth       (depth_reg),
        .interval    (interval_reg),
        .res_limited (res_limited),
        .res_tokens  (res_tokens),
        .res_new     (res_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {res_new, res_tokens, res_limited};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready)
        else $error("ready while busy");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result overwritten");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !m_axis_tready |=> out_vld_reg)
        else $error("result dropped");
`endif

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-key token bucket limiter: a behavioural
// bucket table predicts every result; random keys, times and stalls.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic                       new_entry;
        logic [pktb_pkg::TOK_W-1:0] tokens_left;
        logic                       limited;
    } verdict_t;

    class bucket_scoreboard;
        logic [pktb_pkg::TOK_W-1:0]  depth;
        logic [pktb_pkg::IVL_W-1:0]  interval;
        logic [pktb_pkg::KEY_W-1:0]  keys[pktb_pkg::TABLE_ENTRIES];
        bit                          used[pktb_pkg::TABLE_ENTRIES];
        logic [pktb_pkg::TOK_W-1:0]  tokens[pktb_pkg::TABLE_ENTRIES];
        logic [pktb_pkg::TIME_W-1:0] stamp[pktb_pkg::TABLE_ENTRIES];
        int unsigned                 rank[pktb_pkg::TABLE_ENTRIES];
        verdict_t                    pending[$];
        int                          errors;

        function new();
            depth    = pktb_pkg::DEPTH_RESET;
            interval = pktb_pkg::INTERVAL_RESET;
            errors   = 0;
            foreach (used[i])
            begin
                used[i] = 0;
                rank[i] = 0;
            end
        endfunction

        function void touch(int slot, int unsigned old_rank);
            foreach (used[i])
                if (i != slot && used[i] && rank[i] < old_rank)
                    rank[i]++;
            rank[slot] = 0;
        endfunction

        function void note_request(logic [pktb_pkg::KEY_W-1:0] key,
                                   logic [pktb_pkg::TIME_W-1:0] now);
            int                          slot;
            int unsigned                 old_rank;
            logic [pktb_pkg::TIME_W-1:0] earned;
            logic [pktb_pkg::TIME_W-1:0] ivl;
            logic [pktb_pkg::TIME_W:0]   sum;
            verdict_t                    v;
            slot = -1;
            foreach (used[i])
                if (slot < 0 && used[i] && keys[i] == key)
                    slot = i;
            if (slot < 0)
            begin
                old_rank = 32'hFFFF_FFFF;
                foreach (used[i])
                    if (slot < 0 && !used[i])
                        slot = i;
                if (slot < 0)
                begin
                    slot = 0;
                    foreach (rank[i])
                        if (rank[i] > rank[slot])
                            slot = i;
                    old_rank = rank[slot];
                end
                used[slot]   = 1;
                keys[slot]   = key;
                stamp[slot]  = now;
                tokens[slot] = (depth == 0) ? '0 : depth - 1'b1;
                touch(slot, old_rank);
                v = '{limited: 1'b0, tokens_left: tokens[slot], new_entry: 1'b1};
            end
            else
            begin
                ivl    = (interval == 0) ? 64'd1 : {32'd0, interval};
                earned = (now - stamp[slot]) / ivl;
                if (earned != 0)
                begin
                    if (earned >= depth)
                        sum = depth;
                    else
                    begin
                        sum = tokens[slot] + earned;
                        if (sum > depth)
                            sum = depth;
                    end
                    tokens[slot] = sum[pktb_pkg::TOK_W-1:0];
                    stamp[slot]  = now;
                end
                v.new_entry = 1'b0;
                v.limited   = (tokens[slot] == 0);
                if (!v.limited)
                    tokens[slot]--;
                v.tokens_left = tokens[slot];
                touch(slot, rank[slot]);
            end
            pending.push_back(v);
        endfunction

        function void check_result(verdict_t got);
            verdict_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.limited !== exp.limited)
            begin
                $display("%0t: limited exp %b got %b", $time, exp.limited, got.limited);
                errors++;
            end
            if (got.tokens_left !== exp.tokens_left)
            begin
                $display("%0t: tokens_left exp %0d got %0d", $time,
                         exp.tokens_left, got.tokens_left);
                errors++;
            end
            if (got.new_entry !== exp.new_entry)
            begin
                $display("%0t: new_entry exp %b got %b", $time,
                         exp.new_entry, got.new_entry);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [31:0] cfg_data = '0;

    bucket_scoreboard sb = new();
    int   cycles = 0;
    bit   hold_off = 0;   // long receiver stall
    bit   sink_on = 0;
    logic [pktb_pkg::TIME_W-1:0] clock_ns = 0;
    logic [pktb_pkg::KEY_W-1:0]  key_pool[96];

    localparam int CYCLE_LIMIT = 2_000_000;

    always #10 clk = ~clk;

    per_key_token_bucket_limiter i_dut (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("per_key_token_bucket_limiter test failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // result sink with random stalls
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(verdict_t'(m_axis_tdata[17:0]));
        if (!sink_on || hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) < 70);
    end

    // tvalid stays high after an accept so back-to-back requests need no gap;
    // drain() drops it
    task automatic send_event(logic [pktb_pkg::KEY_W-1:0] key,
                              logic [pktb_pkg::TIME_W-1:0] now);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, key};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(key, now);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic write_reg(pktb_pkg::reg_index_t idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == pktb_pkg::REG_BUCKET_DEPTH)
            sb.depth = value[pktb_pkg::TOK_W-1:0];
        else
            sb.interval = value;
        @(posedge clk);
    endtask

    // random traffic: keys mostly from a pool, time mostly moving forward but at times set at random
    task automatic random_phase(int n, int pool);
        logic [pktb_pkg::KEY_W-1:0] key;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0:       clock_ns = {$urandom, $urandom};
                1:       clock_ns = clock_ns + {$urandom, $urandom} ;
                2, 3:    clock_ns = clock_ns + $urandom;
                default: clock_ns = clock_ns + $urandom_range(0, 3000);
            endcase
            if ($urandom_range(0, 9) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, pool - 1)];
            send_event(key, clock_ns);
        end
    endtask

    initial
    begin
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sink_on = 1;

        // directed: reset settings, extreme keys and times, wrap, emptying
        send_event(32'h0, 64'h0);
        send_event(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(32'h0, 64'h0);
        send_event(32'hFFFF_FFFF, 64'd5);          // elapsed wraps round
        send_event(32'h0, 64'hFFFF_FFFF_FFFF_FFF0); // large refill, saturates
        drain();
        write_reg(pktb_pkg::REG_BUCKET_DEPTH, 32'd2);
        write_reg(pktb_pkg::REG_REFILL_IVL, 32'd100);
        for (int i = 0; i < 4; i++)
            send_event(32'h5A5A_A5A5, 64'd1000);   // runs dry, then limited
        send_event(32'h5A5A_A5A5, 64'd1150);       // earns one token
        send_event(32'h5A5A_A5A5, 64'd1199);       // nothing earned
        drain();
        write_reg(pktb_pkg::REG_BUCKET_DEPTH, 32'd0);        // zero depth
        write_reg(pktb_pkg::REG_REFILL_IVL, 32'd0);          // zero interval acts as one
        send_event(32'h1234_5678, 64'd7);
        send_event(32'h1234_5678, 64'd7);
        send_event(32'h1234_5678, 64'd9);
        drain();
        write_reg(pktb_pkg::REG_BUCKET_DEPTH, 32'hFFFF);
        write_reg(pktb_pkg::REG_REFILL_IVL, 32'hFFFF_FFFF);
        send_event(32'h8000_0000, 64'h8000_0000_0000_0000);
        send_event(32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        drain();

        // more random keys into the table, receiver held off meanwhile
        write_reg(pktb_pkg::REG_BUCKET_DEPTH, 32'd3);
        write_reg(pktb_pkg::REG_REFILL_IVL, 32'd50);
        fork
            begin
                hold_off = 1;
                repeat (2000) @(posedge clk);
                hold_off = 0;
            end
            random_phase(40, 96);
        join
        drain();

        random_phase(200, 96);
        drain();
        write_reg(pktb_pkg::REG_BUCKET_DEPTH, 32'd1);
        write_reg(pktb_pkg::REG_REFILL_IVL, 32'd1000);
        random_phase(200, 40);
        drain();
        write_reg(pktb_pkg::REG_BUCKET_DEPTH, $urandom_range(1, 65535));
        write_reg(pktb_pkg::REG_REFILL_IVL, $urandom_range(1, 5000));
        random_phase(150, 70);
        drain();
        write_reg(pktb_pkg::REG_BUCKET_DEPTH, 32'd20);
        write_reg(pktb_pkg::REG_REFILL_IVL, 32'd1);
        random_phase(150, 96);
        drain();

        if (sb.errors == 0)
            $display("per_key_token_bucket_limiter test passed");
        else
            $display("per_key_token_bucket_limiter test failed");
        $finish;
    end
endmodule
